>>> rtl/pid_step_with_integral_clamp_defines.svh
// assertion macros used by the pid controller top level
`ifndef PID_STEP_WITH_INTEGRAL_CLAMP_DEFINES_SVH
`define PID_STEP_WITH_INTEGRAL_CLAMP_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define PIDC_ASSERT_NOW(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while in reset
`define PIDC_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/pidc_pkg.sv
// shared widths, constants and register codes of the pid controller
package pidc_pkg;

	localparam int TEMP_W     = 16;
	localparam int TIME_W     = 16;
	localparam int GAIN_W     = 16;
	localparam int DRIVE_W    = 32;
	localparam int CFG_W      = 16;
	localparam int CFG_IDX_W  = 2;

	localparam int ERR_W      = TEMP_W + 1;
	localparam int ERRMAG_W   = TEMP_W;
	localparam int DIFF_W     = ERR_W + 1;
	localparam int DIFFMAG_W  = ERR_W;
	localparam int INTEG_W    = 25;
	localparam int INCSUM_W   = 29;
	localparam int ETPROD_W   = ERRMAG_W + TIME_W;
	localparam int DIVI_N_W   = ETPROD_W + 1;
	localparam int DIVI_D_W   = 7;
	localparam int INC_W      = 27;
	localparam int DERIV_W    = 27;
	localparam int TP_W       = ERRMAG_W + GAIN_W + 1;
	localparam int TIFULL_W   = INTEG_W + GAIN_W + 1;
	localparam int TI_W       = TIFULL_W - 4;
	localparam int TD_W       = DERIV_W + GAIN_W + 1;
	localparam int SUM_W      = 45;

	// error*16*t/1000 is worked as (2*error*t)/125
	localparam logic [DIVI_D_W-1:0] DIVI_DIVISOR = 7'd125;
	localparam logic [CFG_W-1:0]    LIMIT_RESET  = 16'd2000;

	localparam logic [DRIVE_W-1:0] DRIVE_MAX = 32'h7fff_ffff;
	localparam logic [DRIVE_W-1:0] DRIVE_MIN = 32'h8000_0000;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_KP    = 2'd0,
		REG_KI    = 2'd1,
		REG_KD    = 2'd2,
		REG_LIMIT = 2'd3
	} cfg_reg_t;

endpackage

>>> rtl/pidc_ifs.sv
// valid/ready channel interfaces for samples in and drive words out
interface pidc_sample_if import pidc_pkg::*;;
	logic                     valid;
	logic                     ready;
	logic signed [TEMP_W-1:0] target_temp;
	logic signed [TEMP_W-1:0] measured_temp;
	logic        [TIME_W-1:0] elapsed_ms;

	modport source (output valid, output target_temp, output measured_temp,
		output elapsed_ms, input ready);
	modport sink (input valid, input target_temp, input measured_temp,
		input elapsed_ms, output ready);
endinterface

interface pidc_result_if import pidc_pkg::*;;
	logic                      valid;
	logic                      ready;
	logic signed [DRIVE_W-1:0] drive;
	logic                      saturated;

	modport source (output valid, output drive, output saturated, input ready);
	modport sink (input valid, input drive, input saturated, output ready);
endinterface

>>> rtl/pid_step_with_integral_clamp.sv
// top level of the pid controller step with integral clamp
//
// Usage: each word on the sample channel carries a setpoint and a measured
// temperature (signed Q12.4) and the milliseconds since the previous word.
// One drive word (signed Q.12, saturated to 32 bits, with a saturated flag)
// comes out on the result channel for every sample taken.
// Gains and the integral limit are written through the register port; the
// user must write them only while no sample is in flight, as the block does
// not enforce it. A write takes effect on the next sample. A sample passes
// a serial multiply of error by time, which starts alongside the kp multiply
// and the derivative divide, then a serial divide by 125 on the integral path,
// then the serial ki and kd multiplies, plus load, clamp, term and sum states.
// A sample with zero elapsed time gives a zero drive word. A new sample is
// taken only after the last leaves the output state; ready is high whenever
// no sample is being worked on. The result register holds a finished word
// while the receiver stalls; the next sample is taken and worked meanwhile,
// and its result waits in the last step until the result register is free.
// Reset clears the integral, the stored error and the gains, sets the limit
// to 2000 and empties the result register.
module pid_step_with_integral_clamp import pidc_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	pidc_sample_if.sink          sample,
	pidc_result_if.source        result,
	input  logic                 write_enable,
	input  logic [CFG_IDX_W-1:0] reg_index,
	input  logic [CFG_W-1:0]     write_data
);

	`include "pid_step_with_integral_clamp_defines.svh"

	typedef enum logic [10:0] {
		S_IDLE  = 11'b000_0000_0001,
		S_LOAD1 = 11'b000_0000_0010,
		S_RUN1  = 11'b000_0000_0100,
		S_LOAD2 = 11'b000_0000_1000,
		S_RUN2  = 11'b000_0001_0000,
		S_CLAMP = 11'b000_0010_0000,
		S_LOAD3 = 11'b000_0100_0000,
		S_RUN3  = 11'b000_1000_0000,
		S_TERM  = 11'b001_0000_0000,
		S_SUM   = 11'b010_0000_0000,
		S_OUT   = 11'b100_0000_0000
	} state_t;

	state_t state_q;

	logic [GAIN_W-1:0] kp_q, ki_q, kd_q;
	logic [CFG_W-1:0]  lim_q;

	logic signed [ERR_W-1:0]   prev_err_q;
	logic signed [INTEG_W-1:0] integral_q;
	logic                      err_neg_q;
	logic [ERRMAG_W-1:0]       err_mag_q;
	logic                      diff_neg_q;
	logic [DIFFMAG_W-1:0]      diff_mag_q;
	logic [TIME_W-1:0]         t_q;
	logic signed [TP_W-1:0]    tp_q;
	logic signed [TI_W-1:0]    ti_q;
	logic signed [TD_W-1:0]    td_q;
	logic signed [SUM_W-1:0]   sum_q;
	logic                      out_valid_q;
	logic [DRIVE_W-1:0]        drive_q;
	logic                      sat_q;

	logic                      take;
	logic                      out_free;
	logic signed [ERR_W-1:0]   err;
	logic signed [DIFF_W-1:0]  diff;
	logic [ERR_W-1:0]          err_abs;
	logic [DIFF_W-1:0]         diff_abs;
	logic [DERIV_W-1:0]        diff_scaled;
	logic signed [INCSUM_W-1:0] inc_s, integ_next, lim_w;
	logic [INTEG_W-1:0]        integ_abs;
	logic signed [INTEG_W-1:0] lim_s;
	logic signed [TIFULL_W-1:0] ti_full;
	logic                      sum_fits;

	logic                        et_start, dd_start, di_start, gm_start;
	logic                        et_busy, kp_busy, dd_busy, di_busy, ki_busy, kd_busy;
	logic [ETPROD_W-1:0]         et_prod;
	logic [ERRMAG_W+GAIN_W-1:0]  kp_prod;
	logic [DERIV_W-1:0]          dd_quo;
	logic [DIVI_N_W-1:0]         di_quo;
	logic [INTEG_W+GAIN_W-1:0]   ki_prod;
	logic [DERIV_W+GAIN_W-1:0]   kd_prod;

	assign take     = sample.valid && sample.ready;
	assign out_free = !out_valid_q || result.ready;

	assign sample.ready     = state_q == S_IDLE;
	assign result.valid     = out_valid_q;
	assign result.drive     = drive_q;
	assign result.saturated = sat_q;

	assign et_start = state_q == S_LOAD1;
	assign dd_start = state_q == S_LOAD1;
	assign di_start = state_q == S_LOAD2;
	assign gm_start = state_q == S_LOAD3;

	assign err      = {sample.target_temp[TEMP_W-1], sample.target_temp}
		- {sample.measured_temp[TEMP_W-1], sample.measured_temp};
	assign diff     = {err[ERR_W-1], err} - {prev_err_q[ERR_W-1], prev_err_q};
	assign err_abs  = err[ERR_W-1] ? -err : err;
	assign diff_abs = diff[DIFF_W-1] ? -diff : diff;

	// times 1000 as 1024 - 16 - 8
	assign diff_scaled = {diff_mag_q, 10'b0}
		- {6'b0, diff_mag_q, 4'b0} - {7'b0, diff_mag_q, 3'b0};

	assign inc_s      = {2'b00, di_quo[INC_W-1:0]};
	assign integ_next = {{(INCSUM_W-INTEG_W){integral_q[INTEG_W-1]}}, integral_q}
		+ (err_neg_q ? -inc_s : inc_s);
	assign lim_w      = {5'b0, lim_q, 8'b0};
	assign lim_s      = {1'b0, lim_q, 8'b0};
	assign integ_abs  = integral_q[INTEG_W-1] ? -integral_q : integral_q;

	assign ti_full  = integral_q[INTEG_W-1] ? -{1'b0, ki_prod} : {1'b0, ki_prod};
	assign sum_fits = (&sum_q[SUM_W-1:DRIVE_W-1]) || !(|sum_q[SUM_W-1:DRIVE_W-1]);

	pidc_sermul #(.WA(ERRMAG_W), .WB(TIME_W)) u_mul_et (
		.clk(clk), .arst_n(arst_n), .start(et_start),
		.a(err_mag_q), .b(t_q), .busy(et_busy), .prod(et_prod)
	);

	pidc_sermul #(.WA(ERRMAG_W), .WB(GAIN_W)) u_mul_kp (
		.clk(clk), .arst_n(arst_n), .start(et_start),
		.a(err_mag_q), .b(kp_q), .busy(kp_busy), .prod(kp_prod)
	);

	pidc_serdiv #(.WN(DERIV_W), .WD(TIME_W)) u_div_deriv (
		.clk(clk), .arst_n(arst_n), .start(dd_start),
		.dividend(diff_scaled), .divisor(t_q), .busy(dd_busy), .quotient(dd_quo)
	);

	pidc_serdiv #(.WN(DIVI_N_W), .WD(DIVI_D_W)) u_div_integ (
		.clk(clk), .arst_n(arst_n), .start(di_start),
		.dividend({et_prod, 1'b0}), .divisor(DIVI_DIVISOR),
		.busy(di_busy), .quotient(di_quo)
	);

	pidc_sermul #(.WA(INTEG_W), .WB(GAIN_W)) u_mul_ki (
		.clk(clk), .arst_n(arst_n), .start(gm_start),
		.a(integ_abs), .b(ki_q), .busy(ki_busy), .prod(ki_prod)
	);

	pidc_sermul #(.WA(DERIV_W), .WB(GAIN_W)) u_mul_kd (
		.clk(clk), .arst_n(arst_n), .start(gm_start),
		.a(dd_quo), .b(kd_q), .busy(kd_busy), .prod(kd_prod)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_q  <= '0;
			ki_q  <= '0;
			kd_q  <= '0;
			lim_q <= LIMIT_RESET;
		end else if (write_enable) begin
			unique case (reg_index)
				REG_KP:    kp_q  <= write_data;
				REG_KI:    ki_q  <= write_data;
				REG_KD:    kd_q  <= write_data;
				REG_LIMIT: lim_q <= write_data;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			prev_err_q <= '0;
			integral_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (take) begin
						if (sample.elapsed_ms == '0) begin
							state_q <= S_OUT;
						end else begin
							prev_err_q <= err;
							state_q    <= S_LOAD1;
						end
					end
				end
				S_LOAD1: state_q <= S_RUN1;
				S_RUN1: begin
					if (!et_busy) begin
						state_q <= S_LOAD2;
					end
				end
				S_LOAD2: state_q <= S_RUN2;
				S_RUN2: begin
					if (!di_busy && !dd_busy) begin
						state_q <= S_CLAMP;
					end
				end
				S_CLAMP: begin
					priority if (integ_next > lim_w) begin
						integral_q <= lim_s;
					end else if (integ_next < -lim_w) begin
						integral_q <= -lim_s;
					end else begin
						integral_q <= integ_next[INTEG_W-1:0];
					end
					state_q <= S_LOAD3;
				end
				S_LOAD3: state_q <= S_RUN3;
				S_RUN3: begin
					if (!ki_busy && !kd_busy && !kp_busy) begin
						state_q <= S_TERM;
					end
				end
				S_TERM: state_q <= S_SUM;
				S_SUM:  state_q <= S_OUT;
				S_OUT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			err_neg_q  <= err[ERR_W-1];
			err_mag_q  <= err_abs[ERRMAG_W-1:0];
			diff_neg_q <= diff[DIFF_W-1];
			diff_mag_q <= diff_abs[DIFFMAG_W-1:0];
			t_q        <= sample.elapsed_ms;
		end
		if (state_q == S_TERM) begin
			tp_q <= err_neg_q ? -{1'b0, kp_prod} : {1'b0, kp_prod};
			// arithmetic shift gives the floor of the divide by 16
			ti_q <= ti_full[TIFULL_W-1:4];
			td_q <= diff_neg_q ? -{1'b0, kd_prod} : {1'b0, kd_prod};
		end
		if (take) begin
			sum_q <= '0;
		end else if (state_q == S_SUM) begin
			sum_q <= {{(SUM_W-TP_W){tp_q[TP_W-1]}}, tp_q}
				+ {{(SUM_W-TI_W){ti_q[TI_W-1]}}, ti_q}
				+ {{(SUM_W-TD_W){td_q[TD_W-1]}}, td_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_OUT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_OUT && out_free) begin
			sat_q   <= !sum_fits;
			drive_q <= sum_fits ? sum_q[DRIVE_W-1:0]
				: (sum_q[SUM_W-1] ? DRIVE_MIN : DRIVE_MAX);
		end
	end

	`PIDC_ASSERT_NOW(a_idle_units_quiet, clk, arst_n, state_q == S_IDLE,
		!(et_busy || kp_busy || dd_busy || di_busy || ki_busy || kd_busy),
		"serial unit still running while idle")

	`PIDC_ASSERT_NOW(a_integral_in_limit, clk, arst_n, state_q == S_LOAD3,
		(integral_q <= lim_s) && (integral_q >= -lim_s),
		"integral outside the clamp after update")

	`PIDC_ASSERT_NEXT(a_zero_time_keeps_state, clk, arst_n,
		take && (sample.elapsed_ms == '0),
		$stable(integral_q) && $stable(prev_err_q),
		"zero elapsed time changed controller state")

	`PIDC_ASSERT_NOW(a_saturated_at_bound, clk, arst_n, result.valid && result.saturated,
		(result.drive == DRIVE_MAX) || (result.drive == DRIVE_MIN),
		"saturated word not at a 32 bit bound")

endmodule

>>> rtl/pidc_sermul.sv
// bit-serial unsigned shift-add multiplier, one multiplier bit per cycle
module pidc_sermul import pidc_pkg::*; #(
	parameter int WA = ERRMAG_W,
	parameter int WB = GAIN_W
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [WA-1:0]    a,
	input  logic [WB-1:0]    b,
	output logic             busy,
	output logic [WA+WB-1:0] prod
);

	localparam int CW = $clog2(WB + 1);

	logic [CW-1:0]    cnt_q;
	logic [WA-1:0]    a_q;
	logic [WA+WB-1:0] prod_q;
	logic [WA:0]      part;

	assign busy = cnt_q != '0;
	assign prod = prod_q;
	assign part = {1'b0, prod_q[WA+WB-1:WB]} + (prod_q[0] ? {1'b0, a_q} : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CW'(WB);
		end else if (busy) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q    <= a;
			prod_q <= {{WA{1'b0}}, b};
		end else if (busy) begin
			prod_q <= {part, prod_q[WB-1:1]};
		end
	end

endmodule

>>> rtl/pidc_serdiv.sv
// restoring unsigned divider, one quotient bit per cycle
module pidc_serdiv import pidc_pkg::*; #(
	parameter int WN = DERIV_W,
	parameter int WD = TIME_W
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [WN-1:0] dividend,
	input  logic [WD-1:0] divisor,
	output logic          busy,
	output logic [WN-1:0] quotient
);

	localparam int CW = $clog2(WN + 1);

	logic [CW-1:0] cnt_q;
	logic [WD-1:0] rem_q;
	logic [WD-1:0] d_q;
	logic [WN-1:0] quo_q;
	logic [WD:0]   cur;
	logic [WD+1:0] trial;

	assign busy     = cnt_q != '0;
	assign quotient = quo_q;
	assign cur      = {rem_q, quo_q[WN-1]};
	assign trial    = {1'b0, cur} - {2'b00, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CW'(WN);
		end else if (busy) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			d_q   <= divisor;
			quo_q <= dividend;
		end else if (busy) begin
			// borrow means the trial subtract failed, keep the partial remainder
			rem_q <= trial[WD+1] ? cur[WD-1:0] : trial[WD-1:0];
			quo_q <= {quo_q[WN-2:0], ~trial[WD+1]};
		end
	end

endmodule

>>> dv/tb_pid_step_with_integral_clamp.sv
// self-checking testbench of the pid controller step with integral clamp
module tb_pid_step_with_integral_clamp;
	import pidc_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam longint DRIVE_HI = 64'sd2147483647;
	localparam longint DRIVE_LO = -64'sd2147483648;

	typedef struct {
		logic signed [TEMP_W-1:0] target;
		logic signed [TEMP_W-1:0] measured;
		logic        [TIME_W-1:0] elapsed;
	} sample_t;

	typedef struct {
		logic signed [DRIVE_W-1:0] drive;
		logic                      saturated;
	} drive_t;

	logic                 clk;
	logic                 arst_n;
	logic                 write_enable;
	logic [CFG_IDX_W-1:0] reg_index;
	logic [CFG_W-1:0]     write_data;

	pidc_sample_if sample_if ();
	pidc_result_if result_if ();

	pid_step_with_integral_clamp u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample       (sample_if),
		.result       (result_if),
		.write_enable (write_enable),
		.reg_index    (reg_index),
		.write_data   (write_data)
	);

	sample_t     sample_q[$];
	drive_t      drive_q[$];
	sample_t     cur_sample;
	drive_t      want;
	int unsigned send_idle;
	int unsigned recv_idle;
	int          mismatches;

	logic [GAIN_W-1:0] kp_q;
	logic [GAIN_W-1:0] ki_q;
	logic [GAIN_W-1:0] kd_q;
	logic [CFG_W-1:0]  limit_q;
	longint            err_prev;
	longint            integ_acc;

	function automatic drive_t compute_drive(sample_t s);
		longint err, t, inc, lim, deriv, kp, ki, kd, ki_term, sum;
		drive_t r;
		r.drive = '0;
		r.saturated = 1'b0;
		t = s.elapsed;
		if (t == 0)
			return r;
		err = longint'(s.target) - longint'(s.measured);
		inc = (err * 16 * t) / 1000;
		integ_acc = integ_acc + inc;
		lim = limit_q;
		lim = lim * 256;
		if (integ_acc > lim)
			integ_acc = lim;
		if (integ_acc < -lim)
			integ_acc = -lim;
		deriv = ((err - err_prev) * 1000) / t;
		err_prev = err;
		kp = kp_q;
		ki = ki_q;
		kd = kd_q;
		// floor division by 16
		ki_term = (ki * integ_acc) >>> 4;
		sum = kp * err + ki_term + kd * deriv;
		if (sum > DRIVE_HI) begin
			sum = DRIVE_HI;
			r.saturated = 1'b1;
		end
		if (sum < DRIVE_LO) begin
			sum = DRIVE_LO;
			r.saturated = 1'b1;
		end
		r.drive = sum[DRIVE_W-1:0];
		return r;
	endfunction

	function automatic sample_t rand_sample();
		sample_t s;
		int unsigned k;
		s.target = TEMP_W'($urandom);
		s.measured = TEMP_W'($urandom);
		k = $urandom_range(9);
		if (k < 5) begin
			// small error around the setpoint
			s.measured = TEMP_W'(s.target + $urandom_range(400) - 200);
		end else if (k == 5) begin
			s.target = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
			s.measured = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
		end
		k = $urandom_range(19);
		if (k == 0)
			s.elapsed = '0;
		else if (k == 1)
			s.elapsed = 16'hffff;
		else if (k < 5)
			s.elapsed = TIME_W'($urandom);
		else if (k < 10)
			s.elapsed = TIME_W'($urandom_range(20, 1));
		else
			s.elapsed = TIME_W'($urandom_range(2000, 1));
		return s;
	endfunction

	function automatic logic [CFG_W-1:0] pick_cfg();
		unique case ($urandom_range(4))
			0: return '0;
			1: return 16'hffff;
			2: return CFG_W'($urandom_range(512, 1));
			default: return CFG_W'($urandom);
		endcase
	endfunction

	task automatic report_mismatch(string msg);
		mismatches++;
		$display("mismatch at %0t: %s", $realtime, msg);
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [CFG_W-1:0] val);
		@(posedge clk);
		write_enable <= 1'b1;
		reg_index <= idx;
		write_data <= val;
		unique case (idx)
			REG_KP: kp_q = val;
			REG_KI: ki_q = val;
			REG_KD: kd_q = val;
			REG_LIMIT: limit_q = val;
			default: ;
		endcase
	endtask

	task automatic load_config(logic [CFG_W-1:0] kp, logic [CFG_W-1:0] ki,
		logic [CFG_W-1:0] kd, logic [CFG_W-1:0] lim);
		write_reg(REG_KP, kp);
		write_reg(REG_KI, ki);
		write_reg(REG_KD, kd);
		write_reg(REG_LIMIT, lim);
		@(posedge clk);
		write_enable <= 1'b0;
	endtask

	task automatic send(logic signed [TEMP_W-1:0] tg, logic signed [TEMP_W-1:0] ms,
		logic [TIME_W-1:0] t);
		sample_t s;
		s.target = tg;
		s.measured = ms;
		s.elapsed = t;
		sample_q.push_back(s);
	endtask

	task automatic wait_idle();
		while (sample_q.size() != 0 || sample_if.valid || drive_q.size() != 0)
			@(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// sample driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_if.valid <= 1'b0;
		end else begin
			if (sample_if.valid && sample_if.ready)
				drive_q.push_back(compute_drive(cur_sample));
			if (!sample_if.valid || sample_if.ready) begin
				if (sample_q.size() != 0 && $urandom_range(99) >= send_idle) begin
					cur_sample = sample_q.pop_front();
					sample_if.valid <= 1'b1;
					sample_if.target_temp <= cur_sample.target;
					sample_if.measured_temp <= cur_sample.measured;
					sample_if.elapsed_ms <= cur_sample.elapsed;
				end else begin
					sample_if.valid <= 1'b0;
				end
			end
		end
	end

	// drive word monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_if.ready <= 1'b0;
		end else begin
			if (result_if.valid && result_if.ready) begin
				if (drive_q.size() == 0) begin
					report_mismatch($sformatf("unexpected word drive %0d", result_if.drive));
				end else begin
					want = drive_q.pop_front();
					if (result_if.drive !== want.drive)
						report_mismatch($sformatf("drive %0d, expected %0d",
							result_if.drive, want.drive));
					if (result_if.saturated !== want.saturated)
						report_mismatch($sformatf("saturated %0b, expected %0b",
							result_if.saturated, want.saturated));
				end
			end
			result_if.ready <= ($urandom_range(99) >= recv_idle);
		end
	end

	initial begin
		#5_000_000;
		$display("FAIL");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		sample_if.valid = 1'b0;
		sample_if.target_temp = '0;
		sample_if.measured_temp = '0;
		sample_if.elapsed_ms = '0;
		result_if.ready = 1'b0;
		write_enable = 1'b0;
		reg_index = REG_KP;
		write_data = '0;
		send_idle = 35;
		recv_idle = 77;
		mismatches = 0;
		kp_q = '0;
		ki_q = '0;
		kd_q = '0;
		limit_q = LIMIT_RESET;
		err_prev = 0;
		integ_acc = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// gains at reset value, state still advances
		send(16'sh7fff, 16'sh8000, 16'd1);
		send(16'sd200, -16'sd300, 16'd40);
		wait_idle();

		load_config(16'hffff, 16'hffff, 16'hffff, 16'hffff);
		send(16'sh7fff, 16'sh8000, 16'd1);
		send(16'sh8000, 16'sh7fff, 16'd1);
		send(16'sd0, 16'sd0, 16'd0);
		send(16'sh8000, 16'sh7fff, 16'hffff);
		send(16'sh7fff, 16'sh8000, 16'hffff);
		send(16'sd100, 16'sd100, 16'd1000);
		wait_idle();

		// zero integral limit
		load_config(16'd256, 16'hffff, 16'd0, 16'd0);
		send(16'sh4000, 16'sd0, 16'd500);
		send(16'shc000, 16'sd0, 16'hffff);
		send(16'sd0, 16'sd0, 16'd0);
		wait_idle();

		// floor of a negative integral term
		load_config(16'd0, 16'd1, 16'd1, 16'd1);
		send(-16'sd5, 16'sd0, 16'd100);
		send(16'sd3, -16'sd3, 16'd7);
		send(-16'sd1, 16'sd0, 16'hffff);
		send(16'sh7fff, 16'sh7fff, 16'd1000);
		wait_idle();

		for (int p = 0; p < 6; p++) begin
			if (p == 2) begin
				send_idle <= 77;
				recv_idle <= 35;
			end
			if (p == 4) begin
				send_idle <= 0;
				recv_idle <= 0;
			end
			load_config(pick_cfg(), pick_cfg(), pick_cfg(), pick_cfg());
			repeat (40) sample_q.push_back(rand_sample());
			wait_idle();
			repeat (40) sample_q.push_back(rand_sample());
			wait_idle();
		end

		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

>>> files.f
+incdir+rtl
rtl/pidc_pkg.sv
rtl/pidc_ifs.sv
rtl/pidc_sermul.sv
rtl/pidc_serdiv.sv
rtl/pid_step_with_integral_clamp.sv
dv/tb_pid_step_with_integral_clamp.sv
